### hw/rtl/ecb_pkg.sv
`default_nettype none

package ecb_pkg;

    localparam int unsigned MAP_ENTRIES_DEF = 65536;
    localparam logic [31:0] PC_LIMIT_RESET  = 32'h0C00_0000;
    localparam int unsigned CMD_Q_DEPTH     = 4;
    localparam int unsigned OUT_Q_DEPTH     = 4;

    localparam logic [1:0] OP_RECORD  = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_INCR,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] slot;
    } t_cmd_tag;

    typedef struct packed {
        logic        recorded;
        logic [15:0] edge_slot;
        logic [7:0]  hit_count;
    } t_result;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

`default_nettype wire

### hw/rtl/edge_coverage_bitmap.sv
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_operation, i_pc, i_initial_state, i_entry_index
// result    out        o_valid / i_stall     o_recorded, o_edge_slot, o_hit_count
// config    in         i_cfg_we              i_cfg_wdata (pc_limit)
//
// One item per cycle sustained while o_stall is low; a transfer enters the command
// queue, then the map read, then increment, map write back and the result queue.
// The map port does one read and one write per cycle; a write to the same entry
// in the previous cycle is forwarded into the increment.
// After reset a clearing pass zeroes the map, one entry per cycle;
// o_stall stays high meanwhile. Configuration writes are taken at any time.
// A four-entry command queue and a four-entry result queue let each side stall alone.
`default_nettype none

module edge_coverage_bitmap
    import ecb_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_pc,
    input  wire logic        i_initial_state,
    input  wire logic [15:0] i_entry_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_recorded,
    output logic [15:0]      o_edge_slot,
    output logic [7:0]       o_hit_count
);

    localparam int unsigned ADDR_W = $clog2(MAP_ENTRIES);
    localparam int unsigned CMD_W  = $bits(t_cmd_tag) + ADDR_W;

    t_back_status      w_status;
    logic              w_q_full;
    logic              w_q_push;
    t_cmd_tag          w_push_tag;
    logic [ADDR_W-1:0] w_push_addr;
    logic              w_q_valid;
    logic              w_q_pop;
    logic [CMD_W-1:0]  w_q_data;
    t_cmd_tag          w_q_tag;
    logic [ADDR_W-1:0] w_q_addr;
    t_result           w_result;

    ecb_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .i_operation     (i_operation),
        .i_pc            (i_pc),
        .i_initial_state (i_initial_state),
        .i_entry_index   (i_entry_index),
        .i_status        (w_status),
        .i_q_full        (w_q_full),
        .o_stall         (o_stall),
        .o_push          (w_q_push),
        .o_tag           (w_push_tag),
        .o_addr          (w_push_addr)
    );

    ecb_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (CMD_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_push_tag, w_push_addr}),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_q_data)
    );

    assign w_q_tag  = w_q_data[CMD_W-1:ADDR_W];
    assign w_q_addr = w_q_data[ADDR_W-1:0];

    ecb_back #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_tag   (w_q_tag),
        .i_q_addr  (w_q_addr),
        .o_q_pop   (w_q_pop),
        .o_status  (w_status),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (w_result)
    );

    assign o_recorded  = w_result.recorded;
    assign o_edge_slot = w_result.edge_slot;
    assign o_hit_count = w_result.hit_count;

`ifndef SYNTHESIS
    a_no_result_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !o_valid)
        else $error("result presented during map clearing");

    a_no_push_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> (!w_q_push && !w_q_pop))
        else $error("command moved during map clearing");

    a_pop_needs_command : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

### hw/rtl/ecb_front.sv
`default_nettype none

module ecb_front
    import ecb_pkg::*;
#(
    parameter int unsigned ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_operation,
    input  wire logic [31:0]       i_pc,
    input  wire logic              i_initial_state,
    input  wire logic [15:0]       i_entry_index,
    input  wire t_back_status      i_status,
    input  wire logic              i_q_full,
    output logic                   o_stall,
    output logic                   o_push,
    output t_cmd_tag               o_tag,
    output logic [ADDR_W-1:0]      o_addr
);

    logic [31:0]       r_pc_limit;
    logic [ADDR_W-2:0] r_prev;
    logic [ADDR_W-2:0] n_prev;
    logic [31:0]       w_hash32;
    logic [ADDR_W-1:0] w_cur;
    logic [ADDR_W-1:0] w_slot;
    logic [31:0]       w_slot32;
    logic [31:0]       w_idx32;
    logic              w_take;

    assign o_stall  = i_status.clearing | i_q_full;
    assign o_push   = i_valid & ~o_stall;

    assign w_hash32 = (i_pc >> 4) ^ (i_pc << 8);
    assign w_cur    = w_hash32[ADDR_W-1:0];
    assign w_slot   = w_cur ^ {1'b0, r_prev};
    assign w_slot32 = 32'(w_slot);
    assign w_idx32  = 32'(i_entry_index);
    assign w_take   = ~i_initial_state & (i_pc <= r_pc_limit);

    always_comb begin
        o_tag.kind = KIND_NONE;
        o_tag.slot = '0;
        o_addr     = '0;
        n_prev     = r_prev;
        case (i_operation)
            OP_RECORD: begin
                if (w_take) begin
                    o_tag.kind = KIND_INCR;
                    o_tag.slot = w_slot32[15:0];
                    o_addr     = w_slot;
                    n_prev     = w_cur[ADDR_W-1:1];
                end
            end
            OP_READ: begin
                o_tag.kind = KIND_READ;
                o_tag.slot = i_entry_index;
                o_addr     = w_idx32[ADDR_W-1:0];
            end
            OP_RESTART: begin
                n_prev = '0;
            end
            default: begin
                n_prev = r_prev;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_limit <= PC_LIMIT_RESET;
            r_prev     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pc_limit <= i_cfg_wdata;
            end
            if (o_push) begin
                r_prev <= n_prev;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ecb_queue.sv
`default_nettype none

module ecb_queue
    import ecb_pkg::*;
#(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = CMD_Q_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output logic [DATA_W-1:0]      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_data  = r_slots[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ecb_back.sv
`default_nettype none

module ecb_back
    import ecb_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF,
    parameter int unsigned ADDR_W      = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_cmd_tag          i_q_tag,
    input  wire logic [ADDR_W-1:0] i_q_addr,
    output logic                   o_q_pop,
    output t_back_status           o_status,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_result                o_result
);

    localparam int unsigned OPTR_W = (OUT_Q_DEPTH > 1) ? $clog2(OUT_Q_DEPTH) : 1;
    localparam int unsigned OCNT_W = $clog2(OUT_Q_DEPTH + 1);

    logic [7:0]        r_mem [MAP_ENTRIES];
    logic [7:0]        r_rd_data;

    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_b_vld;
    t_cmd_tag          r_b_tag;
    logic [ADDR_W-1:0] r_b_addr;

    logic              r_fwd_vld;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [7:0]        r_fwd_data;

    t_result           r_oq [OUT_Q_DEPTH];
    logic [OPTR_W-1:0] r_oq_wr;
    logic [OPTR_W-1:0] r_oq_rd;
    logic [OCNT_W-1:0] r_oq_cnt;

    logic [OCNT_W:0]   w_inflight;
    logic [7:0]        w_base;
    t_result           w_res;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [7:0]        w_wr_data;
    logic              w_out_pop;

    assign o_status.clearing = r_clr_active;

    assign w_inflight = {1'b0, r_oq_cnt} + (OCNT_W + 1)'(r_b_vld);
    assign o_q_pop    = i_q_valid & ~r_clr_active & (w_inflight < (OCNT_W + 1)'(OUT_Q_DEPTH));

    assign w_base = (r_fwd_vld && (r_fwd_addr == r_b_addr)) ? r_fwd_data : r_rd_data;

    always_comb begin
        w_res.recorded  = 1'b0;
        w_res.edge_slot = r_b_tag.slot;
        w_res.hit_count = '0;
        case (r_b_tag.kind)
            KIND_INCR: begin
                w_res.recorded  = 1'b1;
                w_res.hit_count = w_base + 8'd1;
            end
            KIND_READ: begin
                w_res.hit_count = w_base;
            end
            default: begin
                w_res.edge_slot = '0;
            end
        endcase
    end

    always_comb begin
        if (r_clr_active) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = r_b_vld & (r_b_tag.kind == KIND_INCR);
            w_wr_addr = r_b_addr;
            w_wr_data = w_res.hit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= w_wr_addr;
        r_fwd_data <= w_wr_data;
        if (o_q_pop) begin
            r_b_tag  <= i_q_tag;
            r_b_addr <= i_q_addr;
        end
        if (r_b_vld) begin
            r_oq[r_oq_wr] <= w_res;
        end
    end

    assign o_valid   = (r_oq_cnt != '0);
    assign o_result  = r_oq[r_oq_rd];
    assign w_out_pop = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_b_vld      <= 1'b0;
            r_fwd_vld    <= 1'b0;
            r_oq_wr      <= '0;
            r_oq_rd      <= '0;
            r_oq_cnt     <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_b_vld   <= o_q_pop;
            r_fwd_vld <= w_wr_en;
            if (r_b_vld) begin
                r_oq_wr <= (r_oq_wr == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_oq_wr + 1'b1;
            end
            if (w_out_pop) begin
                r_oq_rd <= (r_oq_rd == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : r_oq_rd + 1'b1;
            end
            if (r_b_vld && !w_out_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (w_out_pop && !r_b_vld) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### test/edge_coverage_checker.sv
module edge_coverage_checker
    import ecb_pkg::*;
#(
    parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_pc,
    input  wire logic        i_initial_state,
    input  wire logic [15:0] i_entry_index,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic        i_recorded,
    input  wire logic [15:0] i_edge_slot,
    input  wire logic [7:0]  i_hit_count,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(MAP_ENTRIES);
    localparam logic [31:0] IDX_MASK = MAP_ENTRIES - 1;

    logic [7:0]       hit_map [MAP_ENTRIES];
    logic [IDX_W-1:0] prev_loc;
    logic [31:0]      pc_limit;
    t_result          pending_results [$];
    int               fail_total = 0;
    int               checked_total = 0;

    function automatic t_result edge_hit_update(input logic [1:0] op, input logic [31:0] pc,
                                                input logic init, input logic [15:0] idx);
        t_result          r;
        logic [31:0]      h;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] slot;
        r = '0;
        case (op)
            OP_RECORD: begin
                if (!init && pc <= pc_limit) begin
                    h = (pc >> 4) ^ (pc << 8);
                    cur = h[IDX_W-1:0];
                    slot = cur ^ prev_loc;
                    hit_map[slot] = hit_map[slot] + 8'd1;
                    prev_loc = cur >> 1;
                    r.recorded = 1'b1;
                    r.edge_slot = 16'(32'(slot));
                    r.hit_count = hit_map[slot];
                end
            end
            OP_READ: begin
                r.edge_slot = idx;
                r.hit_count = hit_map[32'(idx) & IDX_MASK];
            end
            OP_RESTART: begin
                prev_loc = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_ENTRIES; i++) hit_map[i] = 8'd0;
            prev_loc = '0;
            pc_limit = PC_LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_we) pc_limit = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(edge_hit_update(i_operation, i_pc,
                                                          i_initial_state, i_entry_index));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing pending: recorded %0d slot %h count %0d",
                             $time, i_recorded, i_edge_slot, i_hit_count);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    checked_total++;
                    if (i_recorded !== want.recorded) begin
                        $display("%0t: recorded mismatch, expected %0d actual %0d",
                                 $time, want.recorded, i_recorded);
                        fail_total++;
                    end
                    if (i_edge_slot !== want.edge_slot) begin
                        $display("%0t: edge_slot mismatch, expected %h actual %h",
                                 $time, want.edge_slot, i_edge_slot);
                        fail_total++;
                    end
                    if (i_hit_count !== want.hit_count) begin
                        $display("%0t: hit_count mismatch, expected %0d actual %0d",
                                 $time, want.hit_count, i_hit_count);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= pending_results.size();
        o_fail_count <= fail_total;
        o_checked <= checked_total;
    end

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ecb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RING = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation = OP_RECORD;
    logic [31:0] i_pc = '0;
    logic        i_initial_state = 1'b0;
    logic [15:0] i_entry_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_recorded;
    logic [15:0] o_edge_slot;
    logic [7:0]  o_hit_count;

    int          fail_count;
    int          pending_count;
    int          checked_count;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          recorded_seen = 0;
    logic [15:0] slot_ring [RING];
    int          ring_wr = 0;
    int          ring_fill = 0;
    logic [31:0] cur_limit = PC_LIMIT_RESET;
    logic [31:0] pc_pool [16];

    edge_coverage_bitmap dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_pc           (i_pc),
        .i_initial_state(i_initial_state),
        .i_entry_index  (i_entry_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_recorded     (o_recorded),
        .o_edge_slot    (o_edge_slot),
        .o_hit_count    (o_hit_count)
    );

    edge_coverage_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_operation    (i_operation),
        .i_pc           (i_pc),
        .i_initial_state(i_initial_state),
        .i_entry_index  (i_entry_index),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_recorded     (o_recorded),
        .i_edge_slot    (o_edge_slot),
        .i_hit_count    (o_hit_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_checked      (checked_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && o_recorded) begin
            slot_ring[ring_wr] <= o_edge_slot;
            ring_wr <= (ring_wr + 1) % RING;
            if (ring_fill < RING) ring_fill <= ring_fill + 1;
            recorded_seen <= recorded_seen + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] pc, input logic init,
                             input logic [15:0] idx);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_pc <= pc;
        i_initial_state <= init;
        i_entry_index <= idx;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_limit = value;
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] pc;
        logic [15:0] idx;
        pick = $urandom_range(99);
        pc = $urandom;
        idx = 16'($urandom);
        if (pick < 60) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: pc = pc_pool[$urandom_range(15)];
                5, 6: pc = cur_limit + $urandom_range(8) - 32'd4;
                default: ;
            endcase
            send_item(OP_RECORD, pc, $urandom_range(19) == 0, idx);
        end else if (pick < 85) begin
            if (ring_fill != 0 && $urandom_range(9) < 7) begin
                idx = slot_ring[$urandom_range(ring_fill - 1)];
            end
            send_item(OP_READ, pc, 1'($urandom_range(1)), idx);
        end else if (pick < 93) begin
            send_item(OP_RESTART, pc, 1'($urandom_range(1)), idx);
        end else if (pick < 97) begin
            send_item(OP_UNUSED, pc, 1'($urandom_range(1)), idx);
        end else begin
            send_item(OP_RECORD, pc, 1'b1, idx);
        end
    endtask

    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < 16; i++) pc_pool[i] = $urandom_range(32'h0C00_0000);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_RECORD, 32'h0000_0000, 1'b0, 16'h0000);
        send_item(OP_RECORD, PC_LIMIT_RESET, 1'b0, 16'hFFFF);
        send_item(OP_RECORD, PC_LIMIT_RESET + 32'd1, 1'b0, 16'h0000);
        send_item(OP_RECORD, 32'hFFFF_FFFF, 1'b0, 16'h0000);
        send_item(OP_RECORD, 32'h0000_1230, 1'b1, 16'h0000);
        send_item(OP_RECORD, 32'h0BFF_FFFF, 1'b0, 16'h0000);
        send_item(OP_READ, 32'hFFFF_FFFF, 1'b1, 16'h0000);
        send_item(OP_READ, 32'h0000_0000, 1'b0, 16'hFFFF);
        send_item(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_item(OP_RECORD, 32'h0000_FFF0, 1'b0, 16'h0000);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_item(OP_RECORD, 32'h00AB_CDE0, 1'b0, 16'h0000);
        write_limit(32'hFFFF_FFFF);
        send_item(OP_RECORD, 32'hFFFF_FFFF, 1'b0, 16'h0000);
        send_item(OP_RECORD, 32'h8000_0000, 1'b0, 16'h0000);
        send_item(OP_READ, 32'h0000_0000, 1'b0, 16'h8000);
        write_limit(32'h0000_0000);
        send_item(OP_RECORD, 32'h0000_0000, 1'b0, 16'h0000);
        send_item(OP_RECORD, 32'h0000_0001, 1'b0, 16'h0000);
        send_item(OP_RECORD, 32'h0000_0000, 1'b1, 16'h0000);
        send_item(OP_RESTART, 32'h0000_0000, 1'b0, 16'h0000);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_limit(32'hFFFF_FFFF);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_limit(PC_LIMIT_RESET);
                    idle_pct = 49;
                    stall_pct = 0;
                end
                2: begin
                    write_limit($urandom);
                    idle_pct = 0;
                    stall_pct = 49;
                end
                default: begin
                    write_limit(32'hFFFF_FFFF);
                    idle_pct = 36;
                    stall_pct = 36;
                end
            endcase
            if (p == 0) begin
                send_item(OP_RESTART, 32'h0000_0000, 1'b0, 16'h0000);
                repeat (300) send_item(OP_RECORD, 32'h0000_0120, 1'b0, 16'($urandom));
                drain();
                send_item(OP_READ, 32'h0000_0000, 1'b0, slot_ring[(ring_wr + RING - 1) % RING]);
            end
            for (int i = 0; i < 85; i++) begin
                random_item();
                if (i == 40) drain();
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        $display("summary: %0d items over four pacing mixes and several pc_limit values,",
                 items_sent);
        $display("summary: %0d results checked, %0d recorded edges, one counter wrapped",
                 checked_count, recorded_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/ecb_pkg.sv
hw/rtl/ecb_front.sv
hw/rtl/ecb_queue.sv
hw/rtl/ecb_back.sv
hw/rtl/edge_coverage_bitmap.sv
test/edge_coverage_checker.sv
test/testbench.sv
